FILE: rtl/mqpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpd_pkg
// Types, codes and defaults for the dispatcher core.
// ----------------------------------------------------------------------------
package mqpd_pkg;

    localparam int CPU_COUNT_DEF   = 4;
    localparam int QUEUE_SLOTS_DEF = 32;

    localparam logic [7:0]  PRIO_TOP  = 8'd140;
    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

    localparam logic [9:0] SLEEP_CAP_RST = 10'd100;
    localparam logic [7:0] PRIO_SPLIT_RST = 8'd120;
    localparam logic [5:0] HIGH_SCALE_RST = 6'd20;
    localparam logic [5:0] LOW_SCALE_RST = 6'd5;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_BALANCE  = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [1:0] CLS_FIFO = 2'd0;

    localparam logic [1:0] CFG_SLEEP_CAP  = 2'd0;
    localparam logic [1:0] CFG_PRIO_SPLIT = 2'd1;
    localparam logic [1:0] CFG_HIGH_SCALE = 2'd2;
    localparam logic [1:0] CFG_LOW_SCALE  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  cpu_index;
        logic [7:0]  task_id;
        logic [1:0]  sched_class;
        logic [7:0]  static_priority;
        logic [15:0] run_time_ms;
        logic [9:0]  slept_ms;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  served_cpu;
        logic [7:0]  chosen_task;
        logic [13:0] quantum_ms;
        logic [15:0] ran_ms;
        logic        finished;
        logic [15:0] remaining_ms;
        logic [9:0]  new_sleep_average;
        logic [20:0] turnaround_ms;
        logic [3:0]  imbalance_mask;
    } t_result;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [1:0]  cls;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [9:0]  sleep_mean;
        logic [19:0] run_total;
        logic [19:0] wait_total;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_QUANT,
        ST_UPDATE,
        ST_SHIFT,
        ST_PLACE
    } t_state;

    function automatic logic [19:0] sat_add20(input logic [19:0] a, input logic [19:0] b);
        logic [20:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[20] ? TOTAL_MAX : s[19:0];
    endfunction

endpackage

FILE: rtl/mqpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/multi_queue_priority_dispatcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_priority_dispatcher_core
// Per-CPU run queues in one slot RAM, with add, priority dispatch and
// balance check transactions.
// ----------------------------------------------------------------------------
// Sequencing: add, balance check, rejected or empty dispatch answer in the cycle
//   after acceptance with o_busy low. A dispatch holds o_busy through the scan,
//   quantum, update, shift and place states, and its result is registered from
//   the place state.
// Throughput: one transaction at a time; the receiver cannot stall results.
// Reset: synchronous active low to default registers, lengths, pointer; RAM kept.
module multi_queue_priority_dispatcher_core
    import mqpd_pkg::*;
#(
    parameter int CPU_COUNT   = CPU_COUNT_DEF,
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_cmd        i_cmd,
    output logic        o_busy,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_wdata
);

    localparam int DEPTH = CPU_COUNT * QUEUE_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(CPU_COUNT);
    localparam int PW    = $clog2(QUEUE_SLOTS);
    localparam int LW    = $clog2(QUEUE_SLOTS + 1);
    localparam int SW    = $clog2(CPU_COUNT * (QUEUE_SLOTS + 1) + 1);

    // Configuration
    logic [9:0] r_sleep_cap;
    logic [7:0] r_prio_split;
    logic [5:0] r_high_scale;
    logic [5:0] r_low_scale;

    // Queue bookkeeping
    logic [CW-1:0] r_next_cpu;
    logic [LW-1:0] r_qlen [CPU_COUNT];

    // Sequencer and dispatch datapath
    t_state        r_state, n_state;
    logic [CW-1:0] r_cpu;
    logic [LW-1:0] r_len;
    logic [AW-1:0] r_base;
    logic [LW-1:0] r_rd;
    logic          r_rvld;
    logic [PW-1:0] r_rpos;
    logic [PW-1:0] r_best;
    t_slot         r_best_ent;
    logic [13:0]   r_qt;
    logic [9:0]    r_slept;
    logic          r_remove;
    t_result       r_res;
    logic          r_out_vld;
    t_result       r_out;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_slot         ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_slot         ram_rdata;

    logic          accept;
    logic [CW-1:0] disp_cpu;
    logic          disp_bad;
    logic          add_full;
    logic [AW-1:0] add_addr;
    logic          issue;
    t_result       idle_res;

    // Balance check
    logic [SW-1:0]        bal_sum;
    logic [SW-1:0]        bal_clen;
    logic [CPU_COUNT-1:0] bal_mask;

    // Update step
    logic [10:0] upd_sum;
    logic [9:0]  upd_capped;
    logic [9:0]  upd_avg;
    logic [20:0] upd_turn;
    logic        upd_fifo;
    logic        upd_fits;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign disp_cpu = CW'(i_cmd.cpu_index);
    assign disp_bad = (32'(i_cmd.cpu_index) >= CPU_COUNT) || (r_qlen[disp_cpu] == '0);
    assign add_full = (32'(r_qlen[r_next_cpu]) >= QUEUE_SLOTS);
    assign add_addr = AW'(r_next_cpu) * AW'(QUEUE_SLOTS)
                    + AW'(r_qlen[r_next_cpu][PW-1:0]);
    assign issue    = (r_rd < r_len);

    // Balance: flag queue i unless C*(len-1) <= sum < C*(len+1)
    always_comb begin
        bal_sum  = '0;
        bal_mask = '0;
        bal_clen = '0;
        for (int i = 0; i < CPU_COUNT; i++) begin
            bal_sum = bal_sum + SW'(r_qlen[i]);
        end
        for (int i = 0; i < CPU_COUNT; i++) begin
            bal_clen    = SW'(CPU_COUNT) * SW'(r_qlen[i]);
            bal_mask[i] = !((bal_clen <= bal_sum + SW'(CPU_COUNT))
                            && (bal_sum < bal_clen + SW'(CPU_COUNT)));
        end
    end

    // Result of a transaction that completes straight from idle
    always_comb begin
        idle_res = '0;
        unique case (i_cmd.opcode)
            OP_ADD: begin
                idle_res.served_cpu = 2'(r_next_cpu);
                if (add_full) begin
                    idle_res.status = STAT_FULL;
                end
            end
            OP_DISPATCH: begin
                idle_res.served_cpu = i_cmd.cpu_index;
                if (disp_bad) begin
                    idle_res.status = STAT_EMPTY;
                end
            end
            OP_BALANCE: begin
                idle_res.imbalance_mask = 4'(bal_mask);
            end
            default: ;
        endcase
    end

    // Sleep average, turnaround and completion for the chosen task
    always_comb begin
        upd_sum    = 11'(r_best_ent.sleep_mean) + 11'(r_slept);
        upd_capped = (upd_sum > 11'(r_sleep_cap)) ? r_sleep_cap : upd_sum[9:0];
        upd_avg    = (14'(upd_capped) > r_qt) ? 10'(14'(upd_capped) - r_qt) : '0;
        upd_turn   = 21'(r_best_ent.run_total) + 21'(r_best_ent.wait_total);
        upd_fifo   = (r_best_ent.cls == CLS_FIFO);
        upd_fits   = (16'(r_qt) >= r_best_ent.remaining);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.opcode == OP_DISPATCH && !disp_bad) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rvld && LW'(r_rpos) == r_len - LW'(1)) begin
                    n_state = ST_QUANT;
                end
            end
            ST_QUANT:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (!issue && !r_rvld) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // RAM controls per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_base + AW'(r_rpos);
        ram_wdata = ram_rdata;
        ram_raddr = r_base + AW'(r_rd[PW-1:0]);
        unique case (r_state)
            ST_IDLE: begin
                ram_waddr = add_addr;
                ram_wdata = '{task_id:    i_cmd.task_id,
                              cls:        i_cmd.sched_class,
                              prio:       i_cmd.static_priority,
                              remaining:  i_cmd.run_time_ms,
                              sleep_mean: '0,
                              run_total:  '0,
                              wait_total: '0};
                ram_we    = accept && (i_cmd.opcode == OP_ADD) && !add_full;
            end
            ST_SHIFT: begin
                ram_we = r_rvld;
            end
            ST_PLACE: begin
                ram_waddr = r_base + AW'(r_len - LW'(1));
                ram_wdata = r_best_ent;
                ram_we    = !r_remove;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mqpd_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_cap  <= SLEEP_CAP_RST;
            r_prio_split <= PRIO_SPLIT_RST;
            r_high_scale <= HIGH_SCALE_RST;
            r_low_scale  <= LOW_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLEEP_CAP:  r_sleep_cap  <= i_cfg_wdata;
                CFG_PRIO_SPLIT: r_prio_split <= i_cfg_wdata[7:0];
                CFG_HIGH_SCALE: r_high_scale <= i_cfg_wdata[5:0];
                CFG_LOW_SCALE:  r_low_scale  <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_next_cpu <= '0;
            r_out_vld  <= 1'b0;
            r_rvld     <= 1'b0;
            for (int i = 0; i < CPU_COUNT; i++) begin
                r_qlen[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            // Strobe a result for a transaction that completes from idle or a finished dispatch
            r_out_vld <= (accept && n_state == ST_IDLE) || (r_state == ST_PLACE);
            if (r_state == ST_SCAN || r_state == ST_SHIFT) begin
                r_rvld <= issue;
            end else begin
                r_rvld <= 1'b0;
            end
            if (accept && i_cmd.opcode == OP_ADD) begin
                // Advance the round-robin pointer even on a rejected add
                r_next_cpu <= (32'(r_next_cpu) == CPU_COUNT - 1) ? '0 : r_next_cpu + CW'(1);
                if (!add_full) begin
                    r_qlen[r_next_cpu] <= r_qlen[r_next_cpu] + LW'(1);
                end
            end
            if (r_state == ST_PLACE && r_remove) begin
                r_qlen[r_cpu] <= r_qlen[r_cpu] - LW'(1);
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_res <= '0;
                if (accept) begin
                    r_out <= idle_res;
                    if (i_cmd.opcode == OP_DISPATCH) begin
                        r_cpu   <= disp_cpu;
                        r_len   <= r_qlen[disp_cpu];
                        r_base  <= AW'(disp_cpu) * AW'(QUEUE_SLOTS);
                        r_slept <= i_cmd.slept_ms;
                        r_rd    <= '0;
                    end
                end
            end
            ST_SCAN: begin
                // Stream the queue through the comparator, keep the first minimum
                if (issue) begin
                    r_rd   <= r_rd + LW'(1);
                    r_rpos <= r_rd[PW-1:0];
                end
                if (r_rvld && (r_rpos == '0 || ram_rdata.prio < r_best_ent.prio)) begin
                    r_best     <= r_rpos;
                    r_best_ent <= ram_rdata;
                end
            end
            ST_QUANT: begin
                if (r_best_ent.prio < PRIO_TOP) begin
                    r_qt <= 14'(PRIO_TOP - r_best_ent.prio)
                          * 14'((r_best_ent.prio < r_prio_split) ? r_high_scale
                                                                 : r_low_scale);
                end else begin
                    r_qt <= '0;
                end
            end
            ST_UPDATE: begin
                r_res.served_cpu  <= 2'(r_cpu);
                r_res.chosen_task <= r_best_ent.task_id;
                r_rd              <= LW'(r_best) + LW'(1);
                if (upd_fifo) begin
                    r_res.ran_ms            <= r_best_ent.remaining;
                    r_res.finished          <= 1'b1;
                    r_res.new_sleep_average <= r_best_ent.sleep_mean;
                    r_res.turnaround_ms     <= upd_turn;
                    r_remove                <= 1'b1;
                end else if (upd_fits) begin
                    r_res.quantum_ms        <= r_qt;
                    r_res.ran_ms            <= r_best_ent.remaining;
                    r_res.finished          <= 1'b1;
                    r_res.new_sleep_average <= upd_avg;
                    r_res.turnaround_ms     <= upd_turn;
                    r_remove                <= 1'b1;
                end else begin
                    r_res.quantum_ms        <= r_qt;
                    r_res.ran_ms            <= 16'(r_qt);
                    r_res.remaining_ms      <= r_best_ent.remaining - 16'(r_qt);
                    r_res.new_sleep_average <= upd_avg;
                    r_best_ent.remaining    <= r_best_ent.remaining - 16'(r_qt);
                    r_best_ent.sleep_mean   <= upd_avg;
                    r_best_ent.run_total    <= sat_add20(r_best_ent.run_total, 20'(r_qt));
                    r_best_ent.wait_total   <= sat_add20(r_best_ent.wait_total, 20'(r_slept));
                    r_remove                <= 1'b0;
                end
            end
            ST_SHIFT: begin
                // Read slot j, write the registered read data back to slot j-1
                if (issue) begin
                    r_rd   <= r_rd + LW'(1);
                    r_rpos <= PW'(r_rd - LW'(1));
                end
            end
            ST_PLACE: begin
                r_out <= r_res;
            end
            default: ;
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule
